>>> rtl/ftp_reply_framer_defines.svh
// ftp_reply_framer_defines.svh: assertion macros for the reply framer
// used by modules that check their own behavior; expects clk and rst in scope
`ifndef FTP_REPLY_FRAMER_DEFINES_SVH
`define FTP_REPLY_FRAMER_DEFINES_SVH

// same-cycle implication, ignored while in reset
`define FTPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define FTPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ftpr_pkg.sv
// ftpr_pkg: shared types, constants and helpers of the ftp reply framer
// no dependencies
package ftpr_pkg;

  localparam int unsigned LINE_COUNT_LIMIT = 255;
  localparam int unsigned LINE_COUNT_CAP_INT =
    (LINE_COUNT_LIMIT < 255) ? LINE_COUNT_LIMIT : 255;
  localparam logic [7:0] LINE_COUNT_CAP = 8'(LINE_COUNT_CAP_INT);

  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_HYPHEN = 8'h2D;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_NINE   = 8'h39;

  localparam logic [2:0] COL_FOURTH = 3'd3;
  localparam logic [2:0] COL_DONE   = 3'd4;

  // kind of the fourth character of a line
  typedef enum logic [1:0] {
    KIND_OTHER  = 2'd0,
    KIND_SPACE  = 2'd1,
    KIND_HYPHEN = 2'd2
  } kind_t;

  // one framed reply
  typedef struct packed {
    logic       valid;
    logic [9:0] code;
    logic       multi;
    logic [7:0] total;
    logic       status;
  } reply_t;

  // three bcd digits to a binary code, at most 15*111 before masking
  function automatic logic [9:0] digits_value(input logic [11:0] d);
    logic [10:0] sum;
    sum = 11'(d[11:8]) * 11'd100 + 11'(d[7:4]) * 11'd10 + 11'(d[3:0]);
    return sum[9:0];
  endfunction

endpackage

>>> rtl/ftpr_line.sv
// ftpr_line: line tracker state and per-byte update of the reply framer
// depends on ftpr_pkg
module ftpr_line import ftpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] data,
  output reply_t     reply
);

  logic [2:0]  column_pos, column_pos_next;
  logic        in_first_line, in_first_line_next;
  logic        multi_mode, multi_mode_next;
  logic [11:0] reply_digits, reply_digits_next;
  logic [11:0] line_digits, line_digits_next;
  logic        line_digits_ok, line_digits_ok_next;
  kind_t       fourth_kind, fourth_kind_next;
  logic        cr_pending, cr_pending_next;
  logic [7:0]  line_counter, line_counter_next;

  logic        starts_ok;
  logic        is_digit;
  logic [3:0]  digit;
  logic [7:0]  count_inc;
  logic        rearm;
  logic        clear_ln;

  // byte classification and line-end bookkeeping
  always_comb begin
    is_digit  = (data >= BYTE_ZERO) && (data <= BYTE_NINE);
    digit     = 4'(data - BYTE_ZERO);
    starts_ok = line_digits_ok && (column_pos >= COL_DONE);
    count_inc = (line_counter < LINE_COUNT_CAP) ? line_counter + 8'd1 : line_counter;
  end

  // next state and reply for the byte on data
  always_comb begin
    column_pos_next     = column_pos;
    in_first_line_next  = in_first_line;
    multi_mode_next     = multi_mode;
    reply_digits_next   = reply_digits;
    line_digits_next    = line_digits;
    line_digits_ok_next = line_digits_ok;
    fourth_kind_next    = fourth_kind;
    cr_pending_next     = cr_pending;
    line_counter_next   = line_counter;
    reply               = '0;
    rearm               = 1'b0;
    clear_ln            = 1'b0;

    if (cr_pending && data == BYTE_LF) begin
      line_counter_next = count_inc;
      reply.total       = count_inc;
      if (in_first_line) begin
        if (starts_ok && fourth_kind == KIND_SPACE) begin
          reply.valid = 1'b1;
          reply.code  = digits_value(line_digits);
          rearm       = 1'b1;
        end else if (starts_ok && fourth_kind == KIND_HYPHEN) begin
          reply_digits_next  = line_digits;
          multi_mode_next    = 1'b1;
          in_first_line_next = 1'b0;
          clear_ln           = 1'b1;
        end else begin
          reply.valid  = 1'b1;
          reply.code   = line_digits_ok ? digits_value(line_digits) : 10'd0;
          reply.status = 1'b1;
          rearm        = 1'b1;
        end
      end else if (multi_mode && starts_ok && fourth_kind == KIND_SPACE &&
                   line_digits == reply_digits) begin
        reply.valid = 1'b1;
        reply.code  = digits_value(reply_digits);
        reply.multi = 1'b1;
        rearm       = 1'b1;
      end else begin
        clear_ln = 1'b1;
      end
    end else begin
      // ordinary line character
      case (column_pos)
        3'd0: begin
          if (is_digit) line_digits_next[11:8] = digit;
          else          line_digits_ok_next    = 1'b0;
        end
        3'd1: begin
          if (is_digit) line_digits_next[7:4] = digit;
          else          line_digits_ok_next   = 1'b0;
        end
        3'd2: begin
          if (is_digit) line_digits_next[3:0] = digit;
          else          line_digits_ok_next   = 1'b0;
        end
        COL_FOURTH: begin
          if (data == BYTE_SPACE)       fourth_kind_next = KIND_SPACE;
          else if (data == BYTE_HYPHEN) fourth_kind_next = KIND_HYPHEN;
          else                          fourth_kind_next = KIND_OTHER;
        end
        default: ;
      endcase
      if (column_pos < COL_DONE) column_pos_next = column_pos + 3'd1;
      cr_pending_next = (data == BYTE_CR);
    end

    // line restart, shared by re-arm
    if (clear_ln || rearm) begin
      column_pos_next     = '0;
      line_digits_next    = '0;
      line_digits_ok_next = 1'b1;
      fourth_kind_next    = KIND_OTHER;
      cr_pending_next     = 1'b0;
    end
    if (rearm) begin
      in_first_line_next = 1'b1;
      multi_mode_next    = 1'b0;
      reply_digits_next  = '0;
      line_counter_next  = '0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos     <= '0;
      in_first_line  <= 1'b1;
      multi_mode     <= 1'b0;
      reply_digits   <= '0;
      line_digits    <= '0;
      line_digits_ok <= 1'b1;
      fourth_kind    <= KIND_OTHER;
      cr_pending     <= 1'b0;
      line_counter   <= '0;
    end else if (step) begin
      column_pos     <= column_pos_next;
      in_first_line  <= in_first_line_next;
      multi_mode     <= multi_mode_next;
      reply_digits   <= reply_digits_next;
      line_digits    <= line_digits_next;
      line_digits_ok <= line_digits_ok_next;
      fourth_kind    <= fourth_kind_next;
      cr_pending     <= cr_pending_next;
      line_counter   <= line_counter_next;
    end
  end

endmodule

>>> rtl/ftp_reply_framer.sv
// ftp_reply_framer: frames ftp control-channel replies from a byte stream
// depends on ftpr_pkg, ftpr_line and ftp_reply_framer_defines.svh
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  rx_byte
//   out      from block out_valid/out_stall  reply_code, multi_line, line_total, status
//
// one byte per cycle sustained while no reply is held by out_stall; a byte is
// latched in the input register, then the line tracker updates and any reply
// lands in the result register, which raises out_valid. in_stall rises only
// while a reply is held by out_stall and a byte waits in the input register.
// rst is synchronous and returns the tracker to the start of a reply.
`include "ftp_reply_framer_defines.svh"

module ftp_reply_framer import ftpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [9:0] reply_code,
  output logic       multi_line,
  output logic [7:0] line_total,
  output logic       status
);

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       advance;
  logic       in_take;
  reply_t     reply;

  // the input register moves on when the result register can take its outcome
  assign advance  = !out_valid || !out_stall;
  assign in_stall = byte_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (advance || !byte_valid) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_data <= rx_byte;
    end
  end

  ftpr_line u_line (
    .clk   (clk),
    .rst   (rst),
    .step  (byte_valid && advance),
    .data  (byte_data),
    .reply (reply)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= byte_valid && reply.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && byte_valid && reply.valid) begin
      reply_code <= reply.code;
      multi_line <= reply.multi;
      line_total <= reply.total;
      status     <= reply.status;
    end
  end

  // a malformed reply always ends on its first line
  `FTPR_ASSERT_NOW(a_malformed_single, out_valid && status,
    !multi_line && line_total == 8'd1, "malformed reply not single line")
  // a multi-line reply needs an opening line and a closing line
  `FTPR_ASSERT_NOW(a_multi_lines, out_valid && multi_line,
    !status && line_total >= 8'd2, "multi-line reply with too few lines")
  // input backpressure only comes from a held reply
  `FTPR_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
    "input stalled without a held reply")
  // a held reply keeps the byte register loaded and stalls the next one
  `FTPR_ASSERT_NEXT(a_hold_byte, in_stall && out_stall, byte_valid,
    "pending byte lost during stall")

endmodule
